@@ sv/lsd_binary_radix_pair_sorter_unit_macros.svh @@
// Assertion macros for the LSD binary radix pair sorter unit.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef LSD_BINARY_RADIX_PAIR_SORTER_UNIT_MACROS_SVH
`define LSD_BINARY_RADIX_PAIR_SORTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSDRPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lsdrps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSDRPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lsdrps assertion failed");

`endif

@@ sv/lsdrps_pkg.sv @@
// Shared constants and types for the LSD binary radix pair sorter unit.
// No dependencies; imported by the cell and the top level.
package lsdrps_pkg;

    localparam int CAPACITY    = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int DATA_WIDTH  = 2 * FIELD_WIDTH;
    localparam int CNT_WIDTH   = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] position;
        logic [KEY_WIDTH-1:0]   key;
    } pair_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

endpackage

@@ sv/lsdrps_cell.sv @@
// One cell of the sorting chain: holds one key/position pair and a valid bit.
// Depends on lsdrps_pkg.
module lsdrps_cell
    import lsdrps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl_i,
    input  pair_t      new_pair_i,
    input  logic       left_take_i,
    input  logic       left_valid_i,
    input  pair_t      left_pair_i,
    input  logic       right_valid_i,
    input  pair_t      right_pair_i,
    output logic       take_o,
    output logic       valid_o,
    output pair_t      pair_o
);

    logic  valid_reg;
    logic  valid_next;
    pair_t pair_reg;
    pair_t pair_next;

    // strictly greater keeps equal keys in arrival order
    assign take_o = !valid_reg || (pair_reg.key > new_pair_i.key);

    always_comb begin
        valid_next = valid_reg;
        pair_next  = pair_reg;
        if (ctrl_i.shift_out) begin
            valid_next = right_valid_i;
            pair_next  = right_pair_i;
        end else if (ctrl_i.insert && take_o) begin
            if (left_take_i) begin
                valid_next = left_valid_i;
                pair_next  = left_pair_i;
            end else begin
                valid_next = 1'b1;
                pair_next  = new_pair_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pair_reg <= pair_next;
    end

    assign valid_o = valid_reg;
    assign pair_o  = pair_reg;

endmodule

@@ sv/lsd_binary_radix_pair_sorter_unit.sv @@
// Top level of the LSD binary radix pair sorter unit.
// Depends on lsdrps_pkg, lsdrps_cell and the assertion macro header.
//
// Usage:
//   The s_ channel takes one key/position pair per word; s_tlast closes the set.
//   Pairs are kept sorted as they arrive in a chain of CAPACITY cells: each new
//   pair is inserted after every held pair whose key is lower or equal, so the
//   order equals a stable ascending sort by key (the LSD radix result).
//   Loading inserts each pair into the chain as it is taken. The cycle after the
//   closing word the m_ channel starts emitting the pairs in ascending key
//   order from the head cell; the whole chain shifts one place per word taken.
//   The cell chain performs a single insert or shift step at a time.
//   m_tlast marks the final pair, m_tuser flags a set in which pairs arriving
//   at a full chain were dropped.
//   s_tready is low while a set is being emitted; a stall on m_tready holds the
//   head pair on m_tdata and freezes the chain.
//   Reset clears the cell valid bits, the pair count and the overflow flag;
//   no clearing pass is needed, the block is ready the cycle after reset.
module lsd_binary_radix_pair_sorter_unit
    import lsdrps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_WIDTH-1:0] s_tdata,   // [31:0] key, [63:32] position
    input  logic                  s_tlast,   // last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_WIDTH-1:0] m_tdata,   // [31:0] sorted_key, [63:32] sorted_position
    output logic                  m_tlast,   // final_result
    output logic                  m_tuser    // overflowed
);

`include "lsd_binary_radix_pair_sorter_unit_macros.svh"

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [CNT_WIDTH-1:0]  count_reg;
    logic                  ovf_reg;

    cell_ctrl_t            ctrl;
    pair_t                 new_pair;
    logic                  in_fire;
    logic                  out_fire;
    logic                  full;

    logic [CAPACITY-1:0]   cell_take;
    logic [CAPACITY-1:0]   cell_valid;
    pair_t                 cell_pair [CAPACITY];

    assign new_pair.key      = s_tdata[KEY_WIDTH-1:0];
    assign new_pair.position = s_tdata[DATA_WIDTH-1:FIELD_WIDTH];

    assign full     = (count_reg == CNT_WIDTH'(CAPACITY));
    assign s_tready = (state_reg == ST_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_EMIT);
    assign out_fire = m_tvalid && m_tready;

    assign ctrl.insert    = in_fire && !full;
    assign ctrl.shift_out = out_fire;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic  left_take;
        logic  left_valid;
        pair_t left_pair;
        logic  right_valid;
        pair_t right_pair;

        if (g == 0) begin : g_head
            assign left_take  = 1'b0;
            assign left_valid = 1'b0;
            assign left_pair  = new_pair;
        end else begin : g_body
            assign left_take  = cell_take[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_pair  = cell_pair[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_pair  = new_pair;
        end else begin : g_inner
            assign right_valid = cell_valid[g+1];
            assign right_pair  = cell_pair[g+1];
        end

        lsdrps_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl_i        (ctrl),
            .new_pair_i    (new_pair),
            .left_take_i   (left_take),
            .left_valid_i  (left_valid),
            .left_pair_i   (left_pair),
            .right_valid_i (right_valid),
            .right_pair_i  (right_pair),
            .take_o        (cell_take[g]),
            .valid_o       (cell_valid[g]),
            .pair_o        (cell_pair[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (in_fire) begin
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + CNT_WIDTH'(1);
                        end
                        if (s_tlast) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_fire) begin
                        count_reg <= count_reg - CNT_WIDTH'(1);
                        if (count_reg == CNT_WIDTH'(1)) begin
                            state_reg <= ST_LOAD;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tdata = {cell_pair[0].position, FIELD_WIDTH'(cell_pair[0].key)};
    assign m_tlast = (count_reg == CNT_WIDTH'(1));
    assign m_tuser = ovf_reg;

    `LSDRPS_ASSERT_IMP(a_emit_head_valid, aclk, aresetn, state_reg == ST_EMIT, cell_valid[0])
    `LSDRPS_ASSERT_IMP(a_count_matches, aclk, aresetn, 1'b1,
        $countones(cell_valid) == int'(count_reg))
    `LSDRPS_ASSERT_IMP(a_head_ordered, aclk, aresetn, cell_valid[1],
        cell_pair[0].key <= cell_pair[1].key)
    `LSDRPS_ASSERT_NXT(a_drop_sets_flag, aclk, aresetn, in_fire && full, ovf_reg)
    `LSDRPS_ASSERT_NXT(a_final_rearms, aclk, aresetn, out_fire && m_tlast,
        state_reg == ST_LOAD && !ovf_reg && count_reg == '0)

endmodule
